[hdl/ethtcp_pkg.sv]
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
// No dependencies; imported by every module of the parser.
package ethtcp_pkg;

    localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
    localparam logic [15:0] ETH_HDR_BYTES   = 16'd14;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [5:0]  MIN_HDR_BYTES   = 6'd20;
    localparam int          QUEUE_DEPTH     = 4;
    localparam int          QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT_ETH   = 4'd1;
    localparam logic [3:0] ST_NOT_IPV4    = 4'd2;
    localparam logic [3:0] ST_NO_IP_HDR   = 4'd3;
    localparam logic [3:0] ST_BAD_IHL     = 4'd4;
    localparam logic [3:0] ST_IP_CUT      = 4'd5;
    localparam logic [3:0] ST_NOT_TCP     = 4'd6;
    localparam logic [3:0] ST_BAD_TOTAL   = 4'd7;
    localparam logic [3:0] ST_NO_TCP_HDR  = 4'd8;
    localparam logic [3:0] ST_BAD_OFFSET  = 4'd9;
    localparam logic [3:0] ST_TCP_CUT     = 4'd10;

    // One queue entry: the results caused by one accepted frame word.
    typedef struct packed {
        logic        pay_v;
        logic [7:0]  pay_byte;
        logic        desc_v;
        logic [3:0]  status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] tcp_sport;
        logic [15:0] tcp_dport;
        logic [31:0] seq;
        logic [2:0]  flags;
        logic [15:0] pay_len;
    } t_entry;

endpackage

[hdl/ethtcp_front.sv]
// Front end: takes frame words, tracks header fields and decides the results.
// Depends on ethtcp_pkg.
module ethtcp_front import ethtcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  logic       i_room,
    output logic       o_ready,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_et, n_et;
    logic [5:0]  r_ihb, n_ihb;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_total, n_total;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [31:0] r_seq, n_seq;
    logic [5:0]  r_thb, n_thb;
    logic [2:0]  r_flags, n_flags;
    logic [15:0] r_budget, n_budget;
    logic [15:0] r_sent, n_sent;

    logic        accept;
    logic [15:0] q, t;
    logic [6:0]  used;
    logic        pay_v;
    logic [3:0]  status;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    always_comb begin
        n_pos = r_pos; n_et = r_et; n_ihb = r_ihb; n_proto = r_proto;
        n_total = r_total; n_src = r_src; n_dst = r_dst; n_sport = r_sport;
        n_dport = r_dport; n_seq = r_seq; n_thb = r_thb; n_flags = r_flags;
        n_budget = r_budget; n_sent = r_sent;
        pay_v = 1'b0;
        q     = r_pos - ETH_HDR_BYTES;
        t     = q - {10'd0, r_ihb};
        used  = 7'd0;
        if (r_pos < MAX_FRAME_BYTES) begin
            n_pos = r_pos + 16'd1;
            if (r_pos == 16'd12) n_et[15:8] = i_byte;
            if (r_pos == 16'd13) n_et[7:0]  = i_byte;
            if (r_pos >= ETH_HDR_BYTES) begin
                if (q == 16'd0) n_ihb = {i_byte[3:0], 2'b00};
                else if (q == 16'd2) n_total[15:8] = i_byte;
                else if (q == 16'd3) n_total[7:0] = i_byte;
                else if (q == 16'd9) n_proto = i_byte;
                else if (q >= 16'd12 && q < 16'd16) n_src = {r_src[23:0], i_byte};
                else if (q >= 16'd16 && q < 16'd20) n_dst = {r_dst[23:0], i_byte};

                if (r_ihb >= MIN_HDR_BYTES && q >= {10'd0, r_ihb}) begin
                    if (t < 16'd2) n_sport = {r_sport[7:0], i_byte};
                    else if (t < 16'd4) n_dport = {r_dport[7:0], i_byte};
                    else if (t < 16'd8) n_seq = {r_seq[23:0], i_byte};
                    else if (t == 16'd12) begin
                        n_thb = {i_byte[7:4], 2'b00};
                        used  = {1'b0, r_ihb} + {1'b0, i_byte[7:4], 2'b00};
                        n_budget = (r_total > {9'd0, used}) ?
                                   r_total - {9'd0, used} : 16'd0;
                    end else if (t == 16'd13) n_flags = i_byte[2:0];

                    if (r_thb >= MIN_HDR_BYTES && t >= {10'd0, r_thb} &&
                        r_et == ETHERTYPE_IPV4 && r_proto == PROTO_TCP &&
                        r_total >= {10'd0, r_ihb} && r_sent < r_budget) begin
                        pay_v  = 1'b1;
                        n_sent = r_sent + 16'd1;
                    end
                end
            end
        end
    end

    // checks in order, on the frame length after this word
    always_comb begin
        if (n_pos < ETH_HDR_BYTES) status = ST_SHORT_ETH;
        else if (n_et != ETHERTYPE_IPV4) status = ST_NOT_IPV4;
        else if (n_pos < 16'd34) status = ST_NO_IP_HDR;
        else if (n_ihb < MIN_HDR_BYTES) status = ST_BAD_IHL;
        else if ({1'b0, n_pos} < 17'd14 + {11'd0, n_ihb}) status = ST_IP_CUT;
        else if (n_proto != PROTO_TCP) status = ST_NOT_TCP;
        else if (n_total < {10'd0, n_ihb}) status = ST_BAD_TOTAL;
        else if ({1'b0, n_pos} < 17'd34 + {11'd0, n_ihb}) status = ST_NO_TCP_HDR;
        else if (n_thb < MIN_HDR_BYTES) status = ST_BAD_OFFSET;
        else if ({1'b0, n_pos} < 17'd14 + {11'd0, n_ihb} + {11'd0, n_thb})
            status = ST_TCP_CUT;
        else status = ST_OK;
    end

    always_comb begin
        o_entry          = '0;
        o_entry.pay_v    = pay_v;
        o_entry.pay_byte = i_byte;
        o_entry.desc_v   = i_end;
        o_entry.status   = status;
        if (status == ST_OK) begin
            o_entry.src_addr  = n_src;
            o_entry.dst_addr  = n_dst;
            o_entry.tcp_sport = n_sport;
            o_entry.tcp_dport = n_dport;
            o_entry.seq       = n_seq;
            o_entry.flags     = n_flags;
            o_entry.pay_len   = n_sent;
        end
    end

    assign o_push = accept && (pay_v || i_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end)) begin
            r_pos <= '0; r_et <= '0; r_ihb <= '0; r_proto <= '0; r_total <= '0;
            r_src <= '0; r_dst <= '0; r_sport <= '0; r_dport <= '0; r_seq <= '0;
            r_thb <= '0; r_flags <= '0; r_budget <= '0; r_sent <= '0;
        end else if (accept) begin
            r_pos <= n_pos; r_et <= n_et; r_ihb <= n_ihb; r_proto <= n_proto;
            r_total <= n_total; r_src <= n_src; r_dst <= n_dst;
            r_sport <= n_sport; r_dport <= n_dport; r_seq <= n_seq;
            r_thb <= n_thb; r_flags <= n_flags; r_budget <= n_budget;
            r_sent <= n_sent;
        end
    end

endmodule

[hdl/ethtcp_queue.sv]
// Short FIFO of result entries between front and back ends.
// Depends on ethtcp_pkg.
module ethtcp_queue import ethtcp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_room,
    output logic   o_valid,
    output t_entry o_head,
    input  logic   i_pop
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;
    logic                pop;

    assign o_room  = r_count < (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

[hdl/ethtcp_back.sv]
// Back end: splits each entry into payload and descriptor words, output register.
// Depends on ethtcp_pkg.
module ethtcp_back import ethtcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_item_kind,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_frame_status,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    output logic [31:0] o_sequence_number,
    output logic [2:0]  o_control_flags,
    output logic [15:0] o_payload_length,
    output logic        o_last_of_run
);

    logic r_pay_done;
    logic load, do_pay;

    assign load   = i_head_valid && (!o_valid || i_ready);
    assign do_pay = i_head.pay_v && !r_pay_done;
    assign o_pop  = load && (!do_pay || !i_head.desc_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid    <= 1'b0;
            r_pay_done <= 1'b0;
        end else begin
            if (load) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            if (load) r_pay_done <= do_pay && i_head.desc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (do_pay) begin
                o_item_kind           <= 1'b0;
                o_payload_byte        <= i_head.pay_byte;
                o_frame_status        <= ST_OK;
                o_source_address      <= '0;
                o_destination_address <= '0;
                o_source_port         <= '0;
                o_destination_port    <= '0;
                o_sequence_number     <= '0;
                o_control_flags       <= '0;
                o_payload_length      <= '0;
                o_last_of_run         <= !i_head.desc_v;
            end else begin
                o_item_kind           <= 1'b1;
                o_payload_byte        <= '0;
                o_frame_status        <= i_head.status;
                o_source_address      <= i_head.src_addr;
                o_destination_address <= i_head.dst_addr;
                o_source_port         <= i_head.tcp_sport;
                o_destination_port    <= i_head.tcp_dport;
                o_sequence_number     <= i_head.seq;
                o_control_flags       <= i_head.flags;
                o_payload_length      <= i_head.pay_len;
                o_last_of_run         <= 1'b1;
            end
        end
    end

endmodule

[hdl/ethernet_ipv4_tcp_header_parser.sv]
// Top level of the Ethernet/IPv4/TCP header parser: front end, queue, back end.
// Depends on ethtcp_pkg, ethtcp_front, ethtcp_queue, ethtcp_back.
//
//  channel | handshake                 | words
//  --------+---------------------------+--------------------------------------
//  in      | i_in_valid / o_in_ready   | i_packet_byte, i_end_of_capture
//  out     | o_out_valid / i_out_ready | item_kind .. last_of_run results
//
// One frame word is taken per cycle while o_in_ready is high; the front end
// settles all header state in that cycle. A word causes up to two results
// (payload then descriptor), sent one per cycle from the output register while
// i_out_ready is high. A four-entry queue decouples the sides; o_in_ready drops
// only when it is full. Reset is synchronous and clears all frame state at once.
module ethernet_ipv4_tcp_header_parser import ethtcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_end_of_capture,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_frame_status,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    output logic [31:0] o_sequence_number,
    output logic [2:0]  o_control_flags,
    output logic [15:0] o_payload_length,
    output logic        o_last_of_run
);

    logic   room, push, head_valid, pop;
    t_entry entry, head;

    ethtcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_packet_byte),
        .i_end   (i_end_of_capture),
        .i_room  (room),
        .o_ready (o_in_ready),
        .o_push  (push),
        .o_entry (entry)
    );

    ethtcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_room  (room),
        .o_valid (head_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    ethtcp_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_head_valid          (head_valid),
        .i_head                (head),
        .o_pop                 (pop),
        .o_valid               (o_out_valid),
        .i_ready               (i_out_ready),
        .o_item_kind           (o_item_kind),
        .o_payload_byte        (o_payload_byte),
        .o_frame_status        (o_frame_status),
        .o_source_address      (o_source_address),
        .o_destination_address (o_destination_address),
        .o_source_port         (o_source_port),
        .o_destination_port    (o_destination_port),
        .o_sequence_number     (o_sequence_number),
        .o_control_flags       (o_control_flags),
        .o_payload_length      (o_payload_length),
        .o_last_of_run         (o_last_of_run)
    );

endmodule
